// ----- rtl/vpc_pkg.sv -----
// vpc_pkg: shared types, constants and the control store of the velocity PI controller.
// No dependencies; used by the interfaces, the sequencer, the top level and the bench.
package vpc_pkg;

	// fixed field widths
	localparam int unsigned SPEED_W = 16;
	localparam int unsigned ERR_W   = 17;
	localparam int unsigned DT_W    = 16;
	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned PITCH_W = 15;
	localparam int unsigned MAXP_W  = 14;
	localparam int unsigned ALPHA_W = 17;
	localparam int unsigned LIMIT_W = 15;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DATA_W  = 17;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 17'd65536;
	localparam logic [MAXP_W-1:0]  PITCH_ABS_MAX = 14'd15360;

	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_MAX_PITCH    = 3'd2,
		REG_INVERT       = 3'd3,
		REG_FILTER_ALPHA = 3'd4,
		REG_INTEG_LIMIT  = 3'd5
	} reg_idx_t;

	typedef logic [3:0] step_t;

	// multiplier operand pair for this step
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_FILT,
		MUL_ERR_DT,
		MUL_KP_ERR,
		MUL_KI_CAND,
		MUL_KI_ACC
	} mul_sel_t;

	// what the step does with the product register and the datapath state
	typedef enum logic [2:0] {
		ALU_NOP,
		ALU_FILT_ERR,
		ALU_CAND,
		ALU_LOAD_SUM,
		ALU_ADD_CAND,
		ALU_ADD_ACC,
		ALU_FINISH,
		ALU_EMIT
	} alu_op_t;

	typedef enum logic [1:0] {
		JMP_NEVER,
		JMP_DT_ZERO,
		JMP_ALWAYS
	} cond_t;

	typedef struct packed {
		mul_sel_t mul;
		alu_op_t  alu;
		cond_t    cond;
		step_t    target;
		logic     last;
	} uword_t;

	// datapath -> sequencer
	typedef struct packed {
		logic start;
		logic dt_zero;
		logic stall;
	} seq_stat_t;

	// sequencer -> datapath
	typedef struct packed {
		logic   busy;
		logic   exec;
		uword_t uw;
	} seq_ctl_t;

	localparam step_t STEP_EMIT = 4'd8;

	// control store; the product of step n is consumed by the ALU op of step n+1
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		case (s)
			4'd0: w = '{MUL_FILT,    ALU_NOP,      JMP_DT_ZERO, STEP_EMIT, 1'b0};
			4'd1: w = '{MUL_NONE,    ALU_FILT_ERR, JMP_NEVER,   STEP_EMIT, 1'b0};
			4'd2: w = '{MUL_ERR_DT,  ALU_NOP,      JMP_NEVER,   STEP_EMIT, 1'b0};
			4'd3: w = '{MUL_KP_ERR,  ALU_CAND,     JMP_NEVER,   STEP_EMIT, 1'b0};
			4'd4: w = '{MUL_KI_CAND, ALU_LOAD_SUM, JMP_NEVER,   STEP_EMIT, 1'b0};
			4'd5: w = '{MUL_KI_ACC,  ALU_ADD_CAND, JMP_NEVER,   STEP_EMIT, 1'b0};
			4'd6: w = '{MUL_NONE,    ALU_ADD_ACC,  JMP_NEVER,   STEP_EMIT, 1'b0};
			4'd7: w = '{MUL_NONE,    ALU_FINISH,   JMP_NEVER,   STEP_EMIT, 1'b0};
			4'd8: w = '{MUL_NONE,    ALU_EMIT,     JMP_NEVER,   STEP_EMIT, 1'b1};
			default: w = '{MUL_NONE, ALU_NOP,      JMP_ALWAYS,  STEP_EMIT, 1'b0};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/vpc_if.sv -----
// vpc_if: item, result and register-write channels of the velocity PI controller.
// Depends on vpc_pkg for field widths.
interface vpc_cmd_if;
	logic valid;
	logic ready;
	logic signed [vpc_pkg::SPEED_W-1:0] target_speed;
	logic signed [vpc_pkg::SPEED_W-1:0] measured_speed;
	logic [vpc_pkg::DT_W-1:0] time_step;
	modport source(output valid, target_speed, measured_speed, time_step, input ready);
	modport sink(input valid, target_speed, measured_speed, time_step, output ready);
endinterface

interface vpc_res_if;
	logic valid;
	logic ready;
	logic signed [vpc_pkg::PITCH_W-1:0] pitch_offset;
	logic saturated_flag;
	logic signed [vpc_pkg::ERR_W-1:0] speed_error;
	logic signed [vpc_pkg::SPEED_W-1:0] filtered_speed;
	logic signed [vpc_pkg::SPEED_W-1:0] integral_value;
	modport source(output valid, pitch_offset, saturated_flag, speed_error, filtered_speed,
		integral_value, input ready);
	modport sink(input valid, pitch_offset, saturated_flag, speed_error, filtered_speed,
		integral_value, output ready);
endinterface

interface vpc_cfg_if;
	logic valid;
	logic ready;
	logic [vpc_pkg::IDX_W-1:0] index;
	logic [vpc_pkg::DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/vpc_useq.sv -----
// vpc_useq: step counter and control store lookup for the velocity PI controller.
// Depends on vpc_pkg (uword_t, ucode, seq_stat_t, seq_ctl_t).
module vpc_useq (
	input  logic                clk,
	input  logic                arst_n,
	input  vpc_pkg::seq_stat_t  stat,
	output vpc_pkg::seq_ctl_t   ctl
);

	vpc_pkg::step_t  step_q, step_d;
	logic            busy_q, busy_d;
	vpc_pkg::uword_t uw;
	logic            take;
	logic            exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
		end else begin
			step_q <= step_d;
			busy_q <= busy_d;
		end
	end

	always_comb begin
		uw   = vpc_pkg::ucode(step_q);
		exec = busy_q && !stat.stall;
		take = (uw.cond == vpc_pkg::JMP_ALWAYS) ||
			((uw.cond == vpc_pkg::JMP_DT_ZERO) && stat.dt_zero);
		step_d = step_q;
		busy_d = busy_q;
		if (stat.start) begin
			busy_d = 1'b1;
			step_d = '0;
		end else if (exec) begin
			if (uw.last) begin
				busy_d = 1'b0;
				step_d = '0;
			end else if (take) begin
				step_d = uw.target;
			end else begin
				step_d = step_q + 4'd1;
			end
		end
		ctl.busy = busy_q;
		ctl.exec = exec;
		ctl.uw   = uw;
	end

endmodule

// ----- rtl/velocity_pi_controller_unit.sv -----
// velocity_pi_controller_unit: top level, datapath with one shared 18x18 multiplier.
// Depends on vpc_pkg, vpc_if (channels) and vpc_useq (sequencer).
//
// channel | dir | handshake   | carries
// --------+-----+-------------+--------------------------------------------------
// cfg     | in  | valid/ready | index (3b), data (17b); ready is always high
// cmd     | in  | valid/ready | target_speed, measured_speed, time_step
// res     | out | valid/ready | pitch_offset, saturated_flag, speed_error,
//         |     |             | filtered_speed, integral_value
//
// An item with a nonzero time step runs nine microcode steps; one with a
// zero time step jumps straight from the first step to the result step.
// The step count is set by the single shared multiplier: five products
// per item go through it one after another.
// The result register decouples the output: the next item is taken while a
// result waits; only the result step stalls while that register is full.
// Reset clears the configuration to its defaults and the controller state.
module velocity_pi_controller_unit (
	input logic        clk,
	input logic        arst_n,
	vpc_cfg_if.sink    cfg,
	vpc_cmd_if.sink    cmd,
	vpc_res_if.source  res
);

	// configuration registers
	logic [vpc_pkg::GAIN_W-1:0]  kp_q, ki_q;
	logic [vpc_pkg::MAXP_W-1:0]  maxp_q;
	logic                        inv_q;
	logic [vpc_pkg::ALPHA_W-1:0] alpha_q;
	logic [vpc_pkg::LIMIT_W-1:0] lim_q;

	// latched item
	logic signed [15:0] tgt_q, meas_q;
	logic [15:0]        dt_q;

	// controller state (filter, seed flag, integral, last error, last output)
	logic signed [15:0] filt_q;
	logic               seeded_q;
	logic signed [15:0] acc_q;
	logic signed [16:0] err_q;
	logic signed [14:0] last_out_q;
	logic               last_sat_q;

	// scratch registers of the sequenced datapath
	logic signed [35:0] prod_q;
	logic signed [35:0] sum_q;
	logic signed [15:0] cand_q;
	logic signed [26:0] co_q;   // output with candidate integral
	logic signed [26:0] ko_q;   // output with committed integral

	// result register
	logic               ov_q;
	logic signed [14:0] o_pitch_q;
	logic               o_sat_q;
	logic signed [16:0] o_err_q;
	logic signed [15:0] o_filt_q;
	logic signed [15:0] o_integ_q;

	vpc_pkg::seq_stat_t stat;
	vpc_pkg::seq_ctl_t  ctl;

	logic accept;
	logic load_out;

	vpc_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	assign cfg.ready = 1'b1;
	assign cmd.ready = !ctl.busy;
	assign accept    = cmd.valid && cmd.ready;

	assign stat.start   = accept;
	assign stat.dt_zero = (dt_q == '0);
	assign stat.stall   = (ctl.uw.alu == vpc_pkg::ALU_EMIT) && ov_q && !res.ready;

	assign load_out = ctl.exec && (ctl.uw.alu == vpc_pkg::ALU_EMIT);

	// register writes; the user must write only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= '0;
			ki_q    <= '0;
			maxp_q  <= '0;
			inv_q   <= 1'b0;
			alpha_q <= vpc_pkg::ALPHA_ONE;
			lim_q   <= 15'd32767;
		end else if (cfg.valid) begin
			case (cfg.index)
				vpc_pkg::REG_PROP_GAIN:    kp_q    <= cfg.data[15:0];
				vpc_pkg::REG_INTEG_GAIN:   ki_q    <= cfg.data[15:0];
				vpc_pkg::REG_MAX_PITCH:    maxp_q  <= cfg.data[13:0];
				vpc_pkg::REG_INVERT:       inv_q   <= cfg.data[0];
				vpc_pkg::REG_FILTER_ALPHA: alpha_q <= cfg.data[16:0];
				vpc_pkg::REG_INTEG_LIMIT:  lim_q   <= cfg.data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q  <= cmd.target_speed;
			meas_q <= cmd.measured_speed;
			dt_q   <= cmd.time_step;
		end
	end

	// saturating register views: alpha above one acts as one, limit above 15 deg as 15 deg
	logic [16:0]        alpha_eff;
	logic [13:0]        maxp_eff;
	logic signed [26:0] maxp_s;

	assign alpha_eff = (alpha_q > vpc_pkg::ALPHA_ONE) ? vpc_pkg::ALPHA_ONE : alpha_q;
	assign maxp_eff  = (maxp_q > vpc_pkg::PITCH_ABS_MAX) ? vpc_pkg::PITCH_ABS_MAX : maxp_q;
	assign maxp_s    = signed'({13'd0, maxp_eff});

	// shared multiplier operand select
	logic signed [16:0] diff;
	logic signed [17:0] mul_a, mul_b;

	assign diff = {meas_q[15], meas_q} - {filt_q[15], filt_q};

	always_comb begin
		case (ctl.uw.mul)
			vpc_pkg::MUL_FILT: begin
				mul_a = signed'({1'b0, alpha_eff});
				mul_b = {diff[16], diff};
			end
			vpc_pkg::MUL_ERR_DT: begin
				mul_a = {err_q[16], err_q};
				mul_b = signed'({2'b00, dt_q});
			end
			vpc_pkg::MUL_KP_ERR: begin
				mul_a = signed'({2'b00, kp_q});
				mul_b = {err_q[16], err_q};
			end
			vpc_pkg::MUL_KI_CAND: begin
				mul_a = signed'({2'b00, ki_q});
				mul_b = {{2{cand_q[15]}}, cand_q};
			end
			vpc_pkg::MUL_KI_ACC: begin
				mul_a = signed'({2'b00, ki_q});
				mul_b = {{2{acc_q[15]}}, acc_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// rounded product in Q.16 -> integer step (floor of (p + half) / 2^16)
	logic signed [35:0] prod_rnd;
	logic signed [19:0] prod_hi;
	assign prod_rnd = prod_q + 36'sd32768;
	assign prod_hi  = prod_rnd[35:16];

	// filter blend: filt + alpha*(meas - filt), rounded and clamped; an unseeded filter takes meas
	logic signed [19:0] filt_sum;
	logic signed [15:0] filt_blend, filt_new;
	logic signed [16:0] err_new;

	always_comb begin
		filt_sum = {{4{filt_q[15]}}, filt_q} + prod_hi;
		if (filt_sum > 20'sd32767)
			filt_blend = 16'sh7FFF;
		else if (filt_sum < -20'sd32768)
			filt_blend = -16'sd32768;
		else
			filt_blend = filt_sum[15:0];
		filt_new = seeded_q ? filt_blend : meas_q;
		err_new  = {tgt_q[15], tgt_q} - {filt_new[15], filt_new};
	end

	// candidate integral, clamped to +-limit
	logic signed [20:0] cand_sum, lim_s;
	logic signed [15:0] cand_new;

	always_comb begin
		cand_sum = {{5{acc_q[15]}}, acc_q} + {prod_hi[19], prod_hi};
		lim_s    = signed'({6'd0, lim_q});
		if (cand_sum > lim_s)
			cand_new = lim_s[15:0];
		else if (cand_sum < -lim_s)
			cand_new = -lim_s[15:0];
		else
			cand_new = cand_sum[15:0];
	end

	// PI sum in Q.20, rounded once to Q.10
	logic signed [36:0] pi_tot;
	logic signed [26:0] pi_rnd;
	assign pi_tot = {sum_q[35], sum_q} + {prod_q[35], prod_q} + 37'sd512;
	assign pi_rnd = pi_tot[36:10];

	// anti-windup decision and output shaping
	logic               sat_hi, sat_lo, commit;
	logic signed [26:0] out10, out_sgn, out_clamp;
	logic               sat_new;

	always_comb begin
		sat_hi = (co_q > maxp_s) && (err_q > 17'sd0);
		sat_lo = (co_q < -maxp_s) && (err_q < 17'sd0);
		commit = !sat_hi && !sat_lo;
		out10  = commit ? co_q : ko_q;
		sat_new = (out10 > maxp_s) || (out10 < -maxp_s);
		out_sgn = inv_q ? -out10 : out10;
		if (out_sgn > maxp_s)
			out_clamp = maxp_s;
		else if (out_sgn < -maxp_s)
			out_clamp = -maxp_s;
		else
			out_clamp = out_sgn;
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q     <= '0;
			seeded_q   <= 1'b0;
			acc_q      <= '0;
			err_q      <= '0;
			last_out_q <= '0;
			last_sat_q <= 1'b0;
		end else if (ctl.exec) begin
			case (ctl.uw.alu)
				vpc_pkg::ALU_FILT_ERR: begin
					filt_q   <= filt_new;
					seeded_q <= 1'b1;
					err_q    <= err_new;
				end
				vpc_pkg::ALU_FINISH: begin
					if (commit)
						acc_q <= cand_q;
					last_out_q <= out_clamp[14:0];
					last_sat_q <= sat_new;
				end
				default: ;
			endcase
		end
	end

	// scratch registers
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			if (ctl.uw.mul != vpc_pkg::MUL_NONE)
				prod_q <= mul_a * mul_b;
			case (ctl.uw.alu)
				vpc_pkg::ALU_CAND:     cand_q <= cand_new;
				vpc_pkg::ALU_LOAD_SUM: sum_q  <= prod_q;
				vpc_pkg::ALU_ADD_CAND: co_q   <= pi_rnd;
				vpc_pkg::ALU_ADD_ACC:  ko_q   <= pi_rnd;
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load_out) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_pitch_q <= last_out_q;
			o_sat_q   <= last_sat_q;
			o_err_q   <= err_q;
			o_filt_q  <= filt_q;
			o_integ_q <= acc_q;
		end
	end

	assign res.valid          = ov_q;
	assign res.pitch_offset   = o_pitch_q;
	assign res.saturated_flag = o_sat_q;
	assign res.speed_error    = o_err_q;
	assign res.filtered_speed = o_filt_q;
	assign res.integral_value = o_integ_q;

	// checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd.ready)
		else $error("item accepted while sequencer did not go busy");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!ov_q || res.ready))
		else $error("result register overwritten while still full");

	a_seeded_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.exec && ctl.uw.alu == vpc_pkg::ALU_FINISH) |-> seeded_q)
		else $error("output computed before filter was seeded");

	a_pitch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.pitch_offset <= 15'sd15360 && res.pitch_offset >= -15'sd15360))
		else $error("pitch offset beyond fifteen degrees");

endmodule

// ----- tb/tb_velocity_pi_controller_unit.sv -----
// tb_velocity_pi_controller_unit: self-checking bench for the velocity PI controller.
// Needs vpc_pkg, the vpc_if channel interfaces and velocity_pi_controller_unit.
// A queue-fed driver, a random-stall result sink and an in-bench controller model.
module tb_velocity_pi_controller_unit;

	// indexes past the register list; writes there must be dropped
	localparam logic [vpc_pkg::IDX_W-1:0] FIRST_UNUSED_IDX = 3'd6;
	localparam logic [vpc_pkg::IDX_W-1:0] LAST_UNUSED_IDX  = 3'd7;
	localparam int unsigned SETTLE_CYCLES = 12;  // a bit more than one item's run
	localparam int unsigned RAND_PHASES = 10;
	localparam int unsigned ITEMS_PER_PHASE = 95;

	typedef struct packed {
		logic signed [vpc_pkg::SPEED_W-1:0] target_speed;
		logic signed [vpc_pkg::SPEED_W-1:0] measured_speed;
		logic [vpc_pkg::DT_W-1:0]           time_step;
	} speed_sample_t;

	// item plus the idle cycles the driver inserts ahead of it
	typedef struct {
		speed_sample_t s;
		int unsigned   gap;
	} queued_sample_t;

	typedef struct packed {
		logic signed [vpc_pkg::PITCH_W-1:0] pitch_offset;
		logic                               saturated_flag;
		logic signed [vpc_pkg::ERR_W-1:0]   speed_error;
		logic signed [vpc_pkg::SPEED_W-1:0] filtered_speed;
		logic signed [vpc_pkg::SPEED_W-1:0] integral_value;
	} pitch_result_t;

	logic clk;
	logic arst_n = 1'b1;

	vpc_cmd_if sample_ch();
	vpc_res_if result_ch();
	vpc_cfg_if reg_ch();

	velocity_pi_controller_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (reg_ch),
		.cmd    (sample_ch),
		.res    (result_ch)
	);

	// ---------------------------------------------------------------
	// Bench copy of the registers (reset values) and controller state
	// ---------------------------------------------------------------
	logic [vpc_pkg::GAIN_W-1:0]  kp_gain     = '0;
	logic [vpc_pkg::GAIN_W-1:0]  ki_gain     = '0;
	logic [vpc_pkg::MAXP_W-1:0]  pitch_limit = '0;
	logic                        invert_en   = 1'b0;
	logic [vpc_pkg::ALPHA_W-1:0] alpha_w     = vpc_pkg::ALPHA_ONE;
	logic [vpc_pkg::LIMIT_W-1:0] integ_clamp = 15'd32767;

	logic signed [vpc_pkg::SPEED_W-1:0] flt_speed  = '0;
	logic                               flt_seeded = 1'b0;
	logic signed [vpc_pkg::SPEED_W-1:0] integ_sum  = '0;
	logic signed [vpc_pkg::ERR_W-1:0]   held_error = '0;
	logic signed [vpc_pkg::PITCH_W-1:0] held_pitch = '0;
	logic                               held_sat   = 1'b0;

	queued_sample_t pending_samples[$];
	pitch_result_t  expected_results[$];
	int unsigned    fail_count = 0;

	// chance in percent of an idle gap on the sending and receiving side, set per phase
	int unsigned src_pct  = 0;
	int unsigned sink_pct = 0;

	int unsigned    idle_count;
	int unsigned    stall_left;
	int unsigned    stall_len;
	queued_sample_t head_sample;
	speed_sample_t  taken_sample;
	pitch_result_t  got_result;
	pitch_result_t  want_result;

	function automatic longint clamp_to(input longint x, input longint lo, input longint hi);
		return (x > hi) ? hi : ((x < lo) ? lo : x);
	endfunction

	// One control step. Advances the bench state and returns the result the
	// block must emit. A zero time step leaves everything as it was.
	function automatic pitch_result_t update_controller(input speed_sample_t s);
		longint tgt, meas, dt, alpha, maxp, lim, kp, ki;
		longint fv, err, cand, cand_out, out10;
		bit push_hi, push_lo;
		pitch_result_t r;
		tgt = $signed(s.target_speed);
		meas = $signed(s.measured_speed);
		dt = s.time_step;
		if (dt != 0) begin
			// register values past full scale saturate
			alpha = (alpha_w > vpc_pkg::ALPHA_ONE) ? vpc_pkg::ALPHA_ONE : alpha_w;
			maxp = (pitch_limit > vpc_pkg::PITCH_ABS_MAX) ? vpc_pkg::PITCH_ABS_MAX
				: pitch_limit;
			lim = integ_clamp;
			kp = kp_gain;
			ki = ki_gain;

			// the first live sample seeds the filter, later ones blend in by alpha
			if (!flt_seeded) begin
				fv = meas;
				flt_seeded = 1'b1;
			end else begin
				fv = flt_speed;
				fv = (alpha * meas + (65536 - alpha) * fv + 32768) >>> 16;
				fv = clamp_to(fv, -32768, 32767);
			end
			flt_speed = fv[vpc_pkg::SPEED_W-1:0];

			err = tgt - fv;
			cand = longint'(integ_sum) + ((err * dt + 32768) >>> 16);
			cand = clamp_to(cand, -lim, lim);

			// conditional integration: keep the old integral when the candidate
			// output would drive further into the rail in the error's direction
			cand_out = (kp * err + ki * cand + 512) >>> 10;
			push_hi = (cand_out > maxp) && (err > 0);
			push_lo = (cand_out < -maxp) && (err < 0);
			if (!push_hi && !push_lo)
				integ_sum = cand[vpc_pkg::SPEED_W-1:0];

			out10 = (kp * err + ki * longint'(integ_sum) + 512) >>> 10;
			held_sat = (out10 > maxp) || (out10 < -maxp);
			if (invert_en)
				out10 = -out10;
			out10 = clamp_to(out10, -maxp, maxp);
			held_pitch = out10[vpc_pkg::PITCH_W-1:0];
			held_error = err[vpc_pkg::ERR_W-1:0];
		end
		r.pitch_offset = held_pitch;
		r.saturated_flag = held_sat;
		r.speed_error = held_error;
		r.filtered_speed = flt_speed;
		r.integral_value = integ_sum;
		return r;
	endfunction

	// mostly no gap, sometimes a short one, rarely a long one
	function automatic int unsigned pick_gap(input int unsigned pct);
		if (pct == 0 || $urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(7) == 0)
			return $urandom_range(60, 10);
		return $urandom_range(3, 1);
	endfunction

	// raw register data, all bits random
	function automatic logic [vpc_pkg::DATA_W-1:0] rand_data();
		logic [31:0] v;
		v = $urandom;
		return v[vpc_pkg::DATA_W-1:0];
	endfunction

	// register value: usual range, the ends, or raw 17 bits to hit the masking
	function automatic logic [vpc_pkg::DATA_W-1:0] pick_value(input int unsigned typ_hi,
			input int unsigned top);
		logic [31:0] v;
		case ($urandom_range(9))
			0: v = '0;
			1: v = top;
			2: v = $urandom;
			default: v = $urandom_range(typ_hi);
		endcase
		return v[vpc_pkg::DATA_W-1:0];
	endfunction

	// random item around a phase operating point; some noise, rails and holds mixed in
	function automatic speed_sample_t random_sample(input int aim);
		speed_sample_t s;
		int unsigned pick;
		int t, m, d;
		pick = $urandom_range(99);
		t = $urandom;
		m = $urandom;
		d = $urandom;
		if (pick < 8) begin
			d = 0;
		end else if (pick < 13) begin
			t = $urandom_range(1) ? 32767 : -32768;
			m = $urandom_range(1) ? 32767 : -32768;
			d = $urandom_range(1) ? 65535 : 1;
		end else if (pick >= 25) begin
			t = aim + int'($urandom_range(256)) - 128;
			m = aim + int'($urandom_range(2048)) - 1024;
			d = ($urandom_range(9) == 0) ? $urandom_range(65535, 1) : $urandom_range(1000, 1);
		end
		s.target_speed = t[vpc_pkg::SPEED_W-1:0];
		s.measured_speed = m[vpc_pkg::SPEED_W-1:0];
		s.time_step = d[vpc_pkg::DT_W-1:0];
		return s;
	endfunction

	task automatic queue_sample(input speed_sample_t s);
		queued_sample_t q;
		q.s = s;
		q.gap = pick_gap(src_pct);
		pending_samples.push_back(q);
	endtask

	task automatic queue_fields(input int t, input int m, input int d);
		speed_sample_t s;
		s.target_speed = t[vpc_pkg::SPEED_W-1:0];
		s.measured_speed = m[vpc_pkg::SPEED_W-1:0];
		s.time_step = d[vpc_pkg::DT_W-1:0];
		queue_sample(s);
	endtask

	// Must be called in a rising-edge time step. valid stays up across
	// back-to-back writes; close_writes drops it.
	task automatic write_reg(input logic [vpc_pkg::IDX_W-1:0] idx,
			input logic [vpc_pkg::DATA_W-1:0] val);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= idx;
		reg_ch.data <= val;
		do @(posedge clk); while (!reg_ch.ready);
		case (idx)
			vpc_pkg::REG_PROP_GAIN:    kp_gain = val[vpc_pkg::GAIN_W-1:0];
			vpc_pkg::REG_INTEG_GAIN:   ki_gain = val[vpc_pkg::GAIN_W-1:0];
			vpc_pkg::REG_MAX_PITCH:    pitch_limit = val[vpc_pkg::MAXP_W-1:0];
			vpc_pkg::REG_INVERT:       invert_en = val[0];
			vpc_pkg::REG_FILTER_ALPHA: alpha_w = val[vpc_pkg::ALPHA_W-1:0];
			vpc_pkg::REG_INTEG_LIMIT:  integ_clamp = val[vpc_pkg::LIMIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic close_writes();
		reg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// all items taken, all results back, then let the sequencer settle
	task automatic wait_idle();
		@(negedge clk);
		while (pending_samples.size() != 0 || sample_ch.valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_config();
		write_reg(vpc_pkg::REG_PROP_GAIN, pick_value(16'h0400, 16'hFFFF));
		write_reg(vpc_pkg::REG_INTEG_GAIN, pick_value(16'h0400, 16'hFFFF));
		write_reg(vpc_pkg::REG_MAX_PITCH, pick_value(15360, 16383));
		write_reg(vpc_pkg::REG_INVERT, pick_value(1, 1));
		write_reg(vpc_pkg::REG_FILTER_ALPHA, pick_value(65536, 131071));
		write_reg(vpc_pkg::REG_INTEG_LIMIT, pick_value(32767, 32767));
		if ($urandom_range(2) == 0)
			write_reg(($urandom_range(1) == 0) ? FIRST_UNUSED_IDX : LAST_UNUSED_IDX,
				rand_data());
		close_writes();
	endtask

	// ---------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Item driver: pops the pending queue, holds each item until taken
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			sample_ch.target_speed <= '0;
			sample_ch.measured_speed <= '0;
			sample_ch.time_step <= '0;
			idle_count <= 0;
		end else if (!sample_ch.valid || sample_ch.ready) begin
			if (pending_samples.size() == 0) begin
				sample_ch.valid <= 1'b0;
			end else if (idle_count < pending_samples[0].gap) begin
				sample_ch.valid <= 1'b0;
				idle_count <= idle_count + 1;
			end else begin
				head_sample = pending_samples.pop_front();
				sample_ch.valid <= 1'b1;
				sample_ch.target_speed <= head_sample.s.target_speed;
				sample_ch.measured_speed <= head_sample.s.measured_speed;
				sample_ch.time_step <= head_sample.s.time_step;
				idle_count <= 0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result sink back-pressure
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			result_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			stall_len = pick_gap(sink_pct);
			result_ch.ready <= (stall_len == 0);
			stall_left <= (stall_len == 0) ? 0 : stall_len - 1;
		end
	end

	// ---------------------------------------------------------------
	// Prediction on every taken item, in-order check on every result
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready) begin
				taken_sample.target_speed = sample_ch.target_speed;
				taken_sample.measured_speed = sample_ch.measured_speed;
				taken_sample.time_step = sample_ch.time_step;
				expected_results.push_back(update_controller(taken_sample));
			end
			if (result_ch.valid && result_ch.ready) begin
				got_result.pitch_offset = result_ch.pitch_offset;
				got_result.saturated_flag = result_ch.saturated_flag;
				got_result.speed_error = result_ch.speed_error;
				got_result.filtered_speed = result_ch.filtered_speed;
				got_result.integral_value = result_ch.integral_value;
				if (expected_results.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result with no item outstanding", $realtime);
					fail_count++;
				end else begin
					want_result = expected_results.pop_front();
					if (got_result !== want_result) begin
						if (fail_count < 10) begin
							$display("%0t: mismatch exp pitch=%0d sat=%0b err=%0d filt=%0d integ=%0d",
								$realtime,
								$signed(want_result.pitch_offset), want_result.saturated_flag,
								$signed(want_result.speed_error),
								$signed(want_result.filtered_speed),
								$signed(want_result.integral_value));
							$display("    got pitch=%0d sat=%0b err=%0d filt=%0d integ=%0d",
								$signed(got_result.pitch_offset), got_result.saturated_flag,
								$signed(got_result.speed_error),
								$signed(got_result.filtered_speed),
								$signed(got_result.integral_value));
						end
						fail_count++;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: far beyond the slowest legal run
	// ---------------------------------------------------------------
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Sequence: directed phases, then random phases with fresh settings.
	// Every phase ends with a full drain, so register writes only land on
	// an idle block and the sender is made to wait on the receiver.
	// ---------------------------------------------------------------
	initial begin
		int aim;
		reg_ch.valid = 1'b0;
		reg_ch.index = '0;
		reg_ch.data = '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero gains and zero limit, alpha one
		queue_fields(1000, 2000, 0);            // hold before any live sample: all zero
		queue_fields(32767, -32768, 1);         // seeds the filter, largest positive error
		queue_fields(0, 0, 0);                  // hold repeats the seeded result
		queue_fields(-32768, 32767, 65535);     // largest negative error, integral clamps
		queue_fields(32767, -32768, 65535);
		wait_idle();

		// unity-ish gains, full limit, half alpha
		write_reg(vpc_pkg::REG_PROP_GAIN, 17'h00100);
		write_reg(vpc_pkg::REG_INTEG_GAIN, 17'h00080);
		write_reg(vpc_pkg::REG_MAX_PITCH, 17'd15360);
		write_reg(vpc_pkg::REG_INVERT, 17'd0);
		write_reg(vpc_pkg::REG_FILTER_ALPHA, 17'd32768);
		write_reg(vpc_pkg::REG_INTEG_LIMIT, 17'd32767);
		close_writes();
		queue_fields(4096, 2048, 256);
		queue_fields(32767, -32768, 65535);     // rails high, integral held back
		queue_fields(-32768, 32767, 65535);     // rails low
		queue_fields(0, 0, 0);
		queue_fields(1024, 1024, 1);
		wait_idle();

		// largest gains, zero integral limit, inverted, out-of-range limit and alpha
		write_reg(vpc_pkg::REG_PROP_GAIN, 17'h0FFFF);
		write_reg(vpc_pkg::REG_INTEG_GAIN, 17'h0FFFF);
		write_reg(vpc_pkg::REG_MAX_PITCH, 17'd16383);    // acts as fifteen degrees
		write_reg(vpc_pkg::REG_INVERT, 17'd1);
		write_reg(vpc_pkg::REG_FILTER_ALPHA, 17'd131071); // acts as one
		write_reg(vpc_pkg::REG_INTEG_LIMIT, 17'd0);
		close_writes();
		queue_fields(100, -100, 500);
		queue_fields(-100, 100, 500);
		queue_fields(0, 0, 65535);
		queue_fields(32767, 32767, 1);
		wait_idle();

		// zero output limit, frozen filter, spare indexes must be ignored
		write_reg(vpc_pkg::REG_PROP_GAIN, 17'h00040);
		write_reg(vpc_pkg::REG_INTEG_GAIN, 17'h00300);
		write_reg(vpc_pkg::REG_MAX_PITCH, 17'd0);
		write_reg(vpc_pkg::REG_INVERT, 17'd0);
		write_reg(vpc_pkg::REG_FILTER_ALPHA, 17'd0);
		write_reg(vpc_pkg::REG_INTEG_LIMIT, 17'd1000);
		write_reg(FIRST_UNUSED_IDX, rand_data());
		write_reg(LAST_UNUSED_IDX, rand_data());
		close_writes();
		queue_fields(2000, -5000, 3000);
		queue_fields(-2000, 5000, 3000);
		queue_fields(0, 32767, 65535);
		queue_fields(-32768, -32768, 2);
		queue_fields(500, 0, 0);
		wait_idle();

		// random phases; one of them runs with no idling at all
		for (int p = 0; p < RAND_PHASES; p++) begin
			random_config();
			if (p == 3) begin
				src_pct = 0;
				sink_pct = 0;
			end else begin
				src_pct = $urandom_range(60);
				sink_pct = $urandom_range(60);
			end
			aim = int'($urandom_range(16384)) - 8192;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// occasional set-point step within a phase
				if ($urandom_range(39) == 0)
					aim = int'($urandom_range(16384)) - 8192;
				queue_sample(random_sample(aim));
			end
			wait_idle();
		end

		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/vpc_pkg.sv
rtl/vpc_if.sv
rtl/vpc_useq.sv
rtl/velocity_pi_controller_unit.sv
tb/tb_velocity_pi_controller_unit.sv
